/* hdl/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, codes and controller/datapath interface types for the
// indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int DW    = 32;
  localparam int FW    = 3;
  localparam int PW    = 7;
  localparam int SW    = 2;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [DW-1:0] word_t;

  typedef enum logic [FW-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_GET    = 3'd2,
    FN_SET    = 3'd3,
    FN_REMOVE = 3'd4,
    FN_SEARCH = 3'd5,
    FN_CLEAR  = 3'd6,
    FN_NOP    = 3'd7
  } func_t;

  typedef enum logic [SW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WALK   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_WTAG   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic ptr_init;
    logic step;
    logic rd_en;
    logic wr_tag;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  st_ok;
    logic  pos_eq_cnt;
    logic  cnt_zero;
    logic  walk_last;
    logic  match;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// ile_ctrl
// Request sequencer: decodes a latched request, steps the memory walk and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire ile_pkg::dp_stat_t  st,
  output logic                    idle,
  output ile_pkg::cmd_t           cmd
);

  ile_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ile_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = (state_r == ile_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ile_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ile_pkg::S_DECODE;
        end
      end
      ile_pkg::S_DECODE: begin
        if (!st.st_ok) begin
          state_nxt = ile_pkg::S_RESULT;
        end else begin
          unique case (st.func)
            ile_pkg::FN_APPEND, ile_pkg::FN_SET: begin
              state_nxt = ile_pkg::S_WTAG;
            end
            ile_pkg::FN_INSERT: begin
              if (st.pos_eq_cnt) begin
                state_nxt = ile_pkg::S_WTAG;
              end else begin
                cmd.ptr_init = 1'b1;
                state_nxt    = ile_pkg::S_WALK;
              end
            end
            ile_pkg::FN_GET, ile_pkg::FN_REMOVE: begin
              cmd.ptr_init = 1'b1;
              state_nxt    = ile_pkg::S_WALK;
            end
            ile_pkg::FN_SEARCH: begin
              if (st.cnt_zero) begin
                state_nxt = ile_pkg::S_RESULT;
              end else begin
                cmd.ptr_init = 1'b1;
                state_nxt    = ile_pkg::S_WALK;
              end
            end
            ile_pkg::FN_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = ile_pkg::S_RESULT;
            end
            default: begin
              state_nxt = ile_pkg::S_RESULT;
            end
          endcase
        end
      end
      ile_pkg::S_WALK: begin
        if (st.match) begin
          state_nxt = ile_pkg::S_RESULT;
        end else begin
          cmd.rd_en = 1'b1;
          if (st.walk_last) begin
            state_nxt = ile_pkg::S_DRAIN;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      ile_pkg::S_DRAIN: begin
        if (st.func == ile_pkg::FN_INSERT) begin
          state_nxt = ile_pkg::S_WTAG;
        end else begin
          cmd.cnt_dec = (st.func == ile_pkg::FN_REMOVE);
          state_nxt   = ile_pkg::S_RESULT;
        end
      end
      ile_pkg::S_WTAG: begin
        cmd.wr_tag  = 1'b1;
        cmd.cnt_inc = (st.func != ile_pkg::FN_SET);
        state_nxt   = ile_pkg::S_RESULT;
      end
      ile_pkg::S_RESULT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ile_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ile_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ile_dp.sv */
// ----------------------------------------------------------------------------
// ile_dp
// Datapath: element memory, element count, request registers, walk pointer,
// shift/compare logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire ile_pkg::cmd_t     cmd,
  output ile_pkg::dp_stat_t      st,
  input  wire  [ile_pkg::FW-1:0] in_func,
  input  wire  [ile_pkg::PW-1:0] in_position,
  input  wire  [ile_pkg::DW-1:0] in_value,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [ile_pkg::SW-1:0] out_status,
  output logic [ile_pkg::DW-1:0] out_data,
  output logic                   out_found,
  output logic [ile_pkg::AW-1:0] out_found_position,
  output logic [ile_pkg::CW-1:0] out_count,
  output logic                   out_empty_res
);

  ile_pkg::word_t mem [ile_pkg::DEPTH];

  ile_pkg::func_t func_r;
  ile_pkg::stat_t stat_r, stat_nxt;
  ile_pkg::addr_t pos_r;
  ile_pkg::word_t tag_r;
  ile_pkg::cnt_t  count_r, count_nxt;
  ile_pkg::addr_t ptr_r, ptr_nxt;
  ile_pkg::addr_t ptr_d_r;
  logic           pend_r;
  ile_pkg::word_t rdata_r;
  ile_pkg::word_t data_r;
  logic           found_r;
  ile_pkg::addr_t fpos_r;
  logic           out_valid_r;
  ile_pkg::stat_t out_status_r;
  ile_pkg::word_t out_data_r;
  logic           out_found_r;
  ile_pkg::addr_t out_fpos_r;
  ile_pkg::cnt_t  out_count_r;

  ile_pkg::func_t in_fn;
  ile_pkg::cnt_t  in_pos;
  ile_pkg::addr_t last_idx;
  ile_pkg::addr_t walk_end;
  logic           is_ins;
  logic           is_rem;
  logic           is_srch;
  logic           hit;
  logic           cap;
  logic           we;
  ile_pkg::addr_t wa;
  ile_pkg::word_t wd;

  assign in_fn    = ile_pkg::func_t'(in_func);
  assign in_pos   = ile_pkg::cnt_t'(in_position);
  assign last_idx = ile_pkg::addr_t'(count_r - ile_pkg::cnt_t'(1));
  assign is_ins   = (func_r == ile_pkg::FN_INSERT);
  assign is_rem   = (func_r == ile_pkg::FN_REMOVE);
  assign is_srch  = (func_r == ile_pkg::FN_SEARCH);

  // request check against the count before the operation
  always_comb begin
    stat_nxt = ile_pkg::ST_OK;
    unique case (in_fn)
      ile_pkg::FN_APPEND: begin
        if (count_r >= ile_pkg::cnt_t'(ile_pkg::DEPTH)) stat_nxt = ile_pkg::ST_FULL;
      end
      ile_pkg::FN_INSERT: begin
        priority if (in_pos > count_r) stat_nxt = ile_pkg::ST_RANGE;
        else if (count_r >= ile_pkg::cnt_t'(ile_pkg::DEPTH)) stat_nxt = ile_pkg::ST_FULL;
        else stat_nxt = ile_pkg::ST_OK;
      end
      ile_pkg::FN_GET, ile_pkg::FN_SET, ile_pkg::FN_REMOVE: begin
        if (in_pos >= count_r) stat_nxt = ile_pkg::ST_RANGE;
      end
      default: begin
        stat_nxt = ile_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_fn;
      stat_r <= stat_nxt;
      tag_r  <= in_value;
      pos_r  <= (in_fn == ile_pkg::FN_APPEND) ? ile_pkg::addr_t'(count_r)
                                               : ile_pkg::addr_t'(in_position);
    end
  end

  // walk pointer
  always_comb begin
    unique case (func_r)
      ile_pkg::FN_INSERT: walk_end = pos_r;
      ile_pkg::FN_GET:    walk_end = pos_r;
      default:            walk_end = last_idx;
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    priority if (cmd.ptr_init) begin
      unique case (func_r)
        ile_pkg::FN_INSERT: ptr_nxt = last_idx;
        ile_pkg::FN_SEARCH: ptr_nxt = '0;
        default:            ptr_nxt = pos_r;
      endcase
    end else if (cmd.step) begin
      ptr_nxt = is_ins ? ptr_r - ile_pkg::addr_t'(1) : ptr_r + ile_pkg::addr_t'(1);
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    ptr_d_r <= ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en;
    end
  end

  // handling of the word read in the previous cycle
  assign hit = pend_r && is_srch && !found_r && (rdata_r == tag_r);
  assign cap = pend_r && !is_ins && !is_srch && (ptr_d_r == pos_r);

  always_comb begin
    we = 1'b0;
    wa = pos_r;
    wd = tag_r;
    priority if (cmd.wr_tag) begin
      we = 1'b1;
    end else if (pend_r && is_ins) begin
      we = 1'b1;
      wa = ptr_d_r + ile_pkg::addr_t'(1);
      wd = rdata_r;
    end else if (pend_r && is_rem && (ptr_d_r != pos_r)) begin
      we = 1'b1;
      wa = ptr_d_r - ile_pkg::addr_t'(1);
      wd = rdata_r;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r  <= '0;
      found_r <= 1'b0;
      fpos_r  <= '0;
    end else begin
      if (cap) begin
        data_r <= rdata_r;
      end
      if (hit) begin
        found_r <= 1'b1;
        fpos_r  <= ptr_d_r;
      end
    end
  end

  // element count
  always_comb begin
    count_nxt = count_r;
    priority if (cmd.cnt_clr) count_nxt = '0;
    else if (cmd.cnt_inc) count_nxt = count_r + ile_pkg::cnt_t'(1);
    else if (cmd.cnt_dec) count_nxt = count_r - ile_pkg::cnt_t'(1);
    else count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= stat_r;
      out_data_r   <= data_r;
      out_found_r  <= found_r;
      out_fpos_r   <= fpos_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data           = out_data_r;
  assign out_found          = out_found_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;
  assign out_empty_res      = (out_count_r == '0);

  assign st.func       = func_r;
  assign st.st_ok      = (stat_r == ile_pkg::ST_OK);
  assign st.pos_eq_cnt = (ile_pkg::cnt_t'(pos_r) == count_r);
  assign st.cnt_zero   = (count_r == '0);
  assign st.walk_last  = (ptr_r == walk_end);
  assign st.match      = hit;
  assign st.out_free   = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

/* hdl/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to 64 32-bit tags addressed by position: append, insert,
// get, set, remove, search and clear, one result per request.
// ----------------------------------------------------------------------------
// usage
//   in_*  : request channel (func, position, value), valid/stall handshake
//   out_* : result channel (status, data, found, found_position, count,
//           empty_res), valid/stall handshake, one result per request
//   one request is in work at a time; in_stall is high while it runs
//   steps from accept to result, n entries:
//     clear, unused selector, errors, search on empty list: decode, result
//     append, set, insert at the end: decode, tag write, result
//     get: decode, read at p, drain, result
//     insert at p below n: decode, walk n-1 to p, drain, tag write, result
//     remove at p: decode, walk p up to n-1, drain, result
//     search: decode, walk from 0, stops at the first match
//   the walk moves one entry per cycle through the memory's single read
//   and single write port
//   a new request is taken while the last result still waits in the output
//   register; a stalled receiver holds that result and blocks the next one
//   reset empties the list (count 0) and drops any pending result
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [ile_pkg::FW-1:0] in_func,
  input  wire  [ile_pkg::PW-1:0] in_position,
  input  wire  [ile_pkg::DW-1:0] in_value,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [ile_pkg::SW-1:0] out_status,
  output logic [ile_pkg::DW-1:0] out_data,
  output logic                   out_found,
  output logic [ile_pkg::AW-1:0] out_found_position,
  output logic [ile_pkg::CW-1:0] out_count,
  output logic                   out_empty_res
);

  ile_pkg::cmd_t     cmd;
  ile_pkg::dp_stat_t st;
  logic              idle;

  assign in_stall = !idle;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .idle     (idle),
    .cmd      (cmd)
  );

  ile_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_func            (in_func),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_data           (out_data),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_empty_res      (out_empty_res)
  );

endmodule

`default_nettype wire
